### hw/rtl/matrix4_row_multiply_assert.svh
// Assertion macros for the matrix4_row_multiply checker.
// Depends on signals aclk and aresetn being visible where a macro is used.
`ifndef MATRIX4_ROW_MULTIPLY_ASSERT_SVH
`define MATRIX4_ROW_MULTIPLY_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define M4RM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("matrix4_row_multiply: assertion failed");

// Next-cycle implication, disabled during reset
`define M4RM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("matrix4_row_multiply: assertion failed");

// Next-cycle implication that also holds across reset
`define M4RM_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("matrix4_row_multiply: reset assertion failed");

`endif

### hw/rtl/m4rm_pkg.sv
// Shared types and constants for the matrix4_row_multiply block.
// No dependencies.
package m4rm_pkg;

    localparam int LANES   = 4;
    localparam int WORD_W  = 32;
    localparam int GROUP_W = 2;
    localparam int PROD_W  = 2 * WORD_W;
    localparam int PAIR_W  = PROD_W + 1;
    localparam int SUM_W   = PROD_W + 2;

    // func codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_MULT = 1'b1;

    // saturation limits
    localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [LANES-1:0][WORD_W-1:0] vec_t;
    typedef logic [GROUP_W-1:0] group_t;

    typedef struct packed {
        logic               func;
        group_t             group_index;
        logic signed [31:0] elem0;
        logic signed [31:0] elem1;
        logic signed [31:0] elem2;
        logic signed [31:0] elem3;
    } in_beat_t;

    typedef struct packed {
        group_t             out_group;
        logic signed [31:0] res0;
        logic signed [31:0] res1;
        logic signed [31:0] res2;
        logic signed [31:0] res3;
        logic               saturated;
    } out_beat_t;

    // stage load enables from the top-level control to the lanes
    typedef struct packed {
        logic adv1;
        logic adv2;
        logic adv3;
    } pipe_ctrl_t;

endpackage

### hw/rtl/m4rm_lane.sv
// One output column lane: four multipliers, two-level registered adder tree,
// then shift and saturate. Depends on m4rm_pkg.
module m4rm_lane import m4rm_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic       aclk,
    input  pipe_ctrl_t ctrl,
    input  vec_t       elems,
    input  vec_t       col,
    output word_t      res,
    output logic       sat
);

    logic signed [PROD_W-1:0] prod_reg [LANES];
    logic signed [PAIR_W-1:0] pair_reg [LANES/2];
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  shifted;
    logic [SUM_W-WORD_W:0]    hi_bits;

    // stage 1: products of the beat's elements with this column
    for (genvar k = 0; k < LANES; k++) begin : g_mul
        always_ff @(posedge aclk) begin
            if (ctrl.adv1) begin
                prod_reg[k] <= PROD_W'($signed(elems[k])) * PROD_W'($signed(col[k]));
            end
        end
    end

    // stage 2: pairwise sums
    for (genvar p = 0; p < LANES/2; p++) begin : g_pair
        always_ff @(posedge aclk) begin
            if (ctrl.adv2) begin
                pair_reg[p] <= PAIR_W'(prod_reg[2*p]) + PAIR_W'(prod_reg[2*p+1]);
            end
        end
    end

    // stage 3: full dot product
    always_ff @(posedge aclk) begin
        if (ctrl.adv3) begin
            sum_reg <= SUM_W'(pair_reg[0]) + SUM_W'(pair_reg[1]);
        end
    end

    // drop fraction bits (floor) and clip to one word
    assign shifted = sum_reg >>> FRAC_BITS;
    assign hi_bits = shifted[SUM_W-1:WORD_W-1];
    assign sat     = !((&hi_bits) || !(|hi_bits));

    always_comb begin
        if (!sat) begin
            res = shifted[WORD_W-1:0];
        end else if (shifted[SUM_W-1]) begin
            res = WORD_MIN;
        end else begin
            res = WORD_MAX;
        end
    end

endmodule

### hw/rtl/m4rm_merge.sv
// Merge stage: gathers lane results, ORs the clip flags, holds the output beat.
// Depends on m4rm_pkg.
module m4rm_merge import m4rm_pkg::*; (
    input  logic             aclk,
    input  logic             adv_out,
    input  group_t           group_in,
    input  vec_t             lane_res,
    input  logic [LANES-1:0] lane_sat,
    output out_beat_t        out_beat
);

    out_beat_t out_reg;

    // output register, loaded whenever the slot is free or being taken
    always_ff @(posedge aclk) begin
        if (adv_out) begin
            out_reg.out_group <= group_in;
            out_reg.res0      <= $signed(lane_res[0]);
            out_reg.res1      <= $signed(lane_res[1]);
            out_reg.res2      <= $signed(lane_res[2]);
            out_reg.res3      <= $signed(lane_res[3]);
            out_reg.saturated <= |lane_sat;
        end
    end

    assign out_beat = out_reg;

endmodule

### hw/rtl/matrix4_row_multiply.sv
// A multiply beat passes the product, pair-sum, sum and output registers before it appears on m_data.
// Throughput: one beat per cycle; each pipeline stage holds independently on back-pressure.
// A load beat writes one stored row at acceptance, gives no result, and is seen by the next beat.
// Reset (aresetn low, synchronous) clears all valid bits; the stored matrix is not cleared.
// Depends on m4rm_pkg, m4rm_lane and m4rm_merge.
module matrix4_row_multiply import m4rm_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    vec_t             left_reg [LANES];
    vec_t             elems;
    vec_t             col [LANES];
    vec_t             lane_res;
    logic [LANES-1:0] lane_sat;
    pipe_ctrl_t       ctrl;
    logic             adv_out;
    logic             accept;
    logic             v1_reg, v2_reg, v3_reg, m_valid_reg;
    logic             v1_next, v2_next, v3_next, m_valid_next;
    group_t           grp1_reg, grp2_reg, grp3_reg;

    assign elems  = {s_data.elem3, s_data.elem2, s_data.elem1, s_data.elem0};
    assign accept = s_valid && s_ready;

    // stored left matrix: a load beat writes one row
    always_ff @(posedge aclk) begin
        if (accept && s_data.func == FUNC_LOAD) begin
            left_reg[s_data.group_index] <= elems;
        end
    end

    // lane c sees column c of the stored matrix
    for (genvar c = 0; c < LANES; c++) begin : g_col
        for (genvar k = 0; k < LANES; k++) begin : g_row
            assign col[c][k] = left_reg[k][c];
        end
    end

    // per-stage advance: a stage loads when empty or when its content moves on
    assign adv_out   = !m_valid_reg || m_ready;
    assign ctrl.adv3 = !v3_reg || adv_out;
    assign ctrl.adv2 = !v2_reg || ctrl.adv3;
    assign ctrl.adv1 = !v1_reg || ctrl.adv2;
    assign s_ready   = ctrl.adv1;

    always_comb begin
        v1_next      = ctrl.adv1 ? (accept && s_data.func == FUNC_MULT) : v1_reg;
        v2_next      = ctrl.adv2 ? v1_reg : v2_reg;
        v3_next      = ctrl.adv3 ? v2_reg : v3_reg;
        m_valid_next = adv_out   ? v3_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            v1_reg      <= v1_next;
            v2_reg      <= v2_next;
            v3_reg      <= v3_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // group index travels alongside the lanes
    always_ff @(posedge aclk) begin
        if (ctrl.adv1) begin
            grp1_reg <= s_data.group_index;
        end
        if (ctrl.adv2) begin
            grp2_reg <= grp1_reg;
        end
        if (ctrl.adv3) begin
            grp3_reg <= grp2_reg;
        end
    end

    for (genvar c = 0; c < LANES; c++) begin : g_lane
        m4rm_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .aclk  (aclk),
            .ctrl  (ctrl),
            .elems (elems),
            .col   (col[c]),
            .res   (lane_res[c]),
            .sat   (lane_sat[c])
        );
    end

    m4rm_merge u_merge (
        .aclk     (aclk),
        .adv_out  (adv_out),
        .group_in (grp3_reg),
        .lane_res (lane_res),
        .lane_sat (lane_sat),
        .out_beat (m_data)
    );

    assign m_valid = m_valid_reg;

endmodule

### hw/rtl/m4rm_checker.sv
// Port-level checker for matrix4_row_multiply, bound to the top level.
// Depends on m4rm_pkg and matrix4_row_multiply_assert.svh.
`include "matrix4_row_multiply_assert.svh"

module m4rm_checker import m4rm_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_beat_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_beat_t m_data
);

    // a stalled result beat holds
    `M4RM_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))

    // a result appearing into an empty slot must come from an accepted multiply beat
    `M4RM_ASSERT_IMP(a_rise_src, $rose(m_valid), $past(s_valid && s_ready && s_data.func, 4))

    // with the output slot empty the input side is never blocked
    `M4RM_ASSERT_IMP(a_ready_free, !m_valid, s_ready)

    // reset empties the output
    `M4RM_ASSERT_RST(a_reset_empty, !aresetn, !m_valid)

endmodule

bind matrix4_row_multiply m4rm_checker u_checker (.*);
